[hdl/cbr_pkg.sv]
`default_nettype none

package cbr_pkg;

  localparam int unsigned TABLE_ROWS_DEF = 11;
  localparam int unsigned ROW_IDX_W      = 4;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd600;

  // Block whose payload carries the first memory frequency, and its payload span.
  localparam logic [5:0] FREQ_BLOCK = 6'd8;
  localparam logic [7:0] FREQ_FIRST = 8'd11;
  localparam logic [7:0] FREQ_LAST  = 8'd14;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2,
    OP_DISC  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    EV_ACK     = 2'd0,
    EV_DONE    = 2'd1,
    EV_BAD     = 2'd2,
    EV_TIMEOUT = 2'd3
  } ev_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    ev_t         ev;
    logic [5:0]  blk;
    logic        fv;
    logic [31:0] freq;
  } res_t;

  function automatic logic [7:0] row_len(input logic [ROW_IDX_W-1:0] row);
    logic [7:0] len;
    case (row)
      4'd0:    len = 8'd2;
      4'd1:    len = 8'd40;
      4'd2:    len = 8'd208;
      4'd3:    len = 8'd182;
      4'd4:    len = 8'd208;
      4'd5:    len = 8'd182;
      4'd6:    len = 8'd198;
      4'd7:    len = 8'd53;
      4'd8:    len = 8'd130;
      4'd9:    len = 8'd118;
      4'd10:   len = 8'd118;
      default: len = 8'd0;
    endcase
    return len;
  endfunction

  function automatic logic [5:0] row_count(input logic [ROW_IDX_W-1:0] row);
    logic [5:0] cnt;
    case (row)
      4'd8:    cnt = 6'd40;
      default: cnt = 6'd1;
    endcase
    return cnt;
  endfunction

endpackage

`default_nettype wire

[hdl/cbr_fifo.sv]
`default_nettype none

module cbr_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  // Two entries: enough for back-to-back transfers on both sides.
  logic [WIDTH-1:0] slot0_r, slot1_r;
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = rd_ptr_r ? slot1_r : slot0_r;

  always_ff @(posedge clk) begin
    if (do_push) begin
      if (wr_ptr_r) begin
        slot1_r <= wdata;
      end else begin
        slot0_r <= wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/cbr_front.sv]
`default_nettype none

module cbr_front
  import cbr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  input  wire logic [1:0] in_opcode,
  input  wire logic [7:0] in_data_byte,
  output logic            in_full,
  input  wire logic       cmd_pop,
  output cmd_t            cmd,
  output logic            cmd_empty
);

  cmd_t                    cmd_in;
  logic [$bits(cmd_t)-1:0] cmd_bits;

  // Only received bytes carry data; other commands get a zero data field.
  always_comb begin
    cmd_in.op = op_t'(in_opcode);
    case (cmd_in.op)
      OP_BYTE: cmd_in.data = in_data_byte;
      default: cmd_in.data = 8'd0;
    endcase
  end

  cbr_fifo #(
    .WIDTH($bits(cmd_t))
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (cmd_in),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (cmd_bits),
    .empty (cmd_empty)
  );

  assign cmd = cmd_t'(cmd_bits);

endmodule

`default_nettype wire

[hdl/cbr_back.sv]
`default_nettype none

module cbr_back
  import cbr_pkg::*;
#(
  parameter int unsigned TABLE_ROWS = TABLE_ROWS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_timeout_ticks,
  input  wire cmd_t        cmd,
  input  wire logic        cmd_empty,
  output logic             cmd_pop,
  input  wire logic        res_full,
  output logic             res_push,
  output res_t             res
);

  localparam logic [ROW_IDX_W:0] ROWS_END = (ROW_IDX_W+1)'(TABLE_ROWS);

  logic [15:0]          timeout_r;
  logic                 recv_r, recv_nxt;
  logic [ROW_IDX_W-1:0] row_r, row_nxt;
  logic [5:0]           rep_r, rep_nxt;
  logic [5:0]           exp_r, exp_nxt;
  logic [7:0]           pos_r, pos_nxt;
  logic                 num_ok_r, num_ok_nxt;
  logic [7:0]           sum_r, sum_nxt;
  logic [31:0]          freq_r, freq_nxt;
  logic [15:0]          tick_r, tick_nxt;

  logic                 fire;
  logic [7:0]           len;
  logic [15:0]          tick_inc;
  logic [5:0]           rep_inc;
  logic [ROW_IDX_W-1:0] row_adv;
  logic                 last;

  assign fire    = !cmd_empty && !res_full;
  assign cmd_pop = fire;
  assign len     = row_len(row_r);

  always_comb begin
    recv_nxt   = recv_r;
    row_nxt    = row_r;
    rep_nxt    = rep_r;
    exp_nxt    = exp_r;
    pos_nxt    = pos_r;
    num_ok_nxt = num_ok_r;
    sum_nxt    = sum_r;
    freq_nxt   = freq_r;
    tick_nxt   = tick_r;
    res_push   = 1'b0;
    res.ev     = EV_ACK;
    res.blk    = exp_r;
    res.fv     = 1'b0;
    res.freq   = 32'd0;
    tick_inc   = (tick_r != 16'hFFFF) ? tick_r + 16'd1 : tick_r;
    rep_inc    = rep_r + 6'd1;
    row_adv    = row_r;
    last       = 1'b0;

    if (fire) begin
      if (cmd.op == OP_START) begin
        if (!recv_r) begin
          recv_nxt   = 1'b1;
          row_nxt    = '0;
          rep_nxt    = 6'd0;
          exp_nxt    = 6'd0;
          pos_nxt    = 8'd0;
          num_ok_nxt = 1'b0;
          sum_nxt    = 8'd0;
          freq_nxt   = 32'd0;
          tick_nxt   = 16'd0;
        end
      end else if (recv_r) begin
        case (cmd.op)
          OP_DISC: begin
            recv_nxt = 1'b0;
          end
          OP_TICK: begin
            tick_nxt = tick_inc;
            if (tick_inc >= timeout_r) begin
              recv_nxt = 1'b0;
              res_push = 1'b1;
              res.ev   = EV_TIMEOUT;
            end
          end
          OP_BYTE: begin
            if (pos_r == 8'd0) begin
              num_ok_nxt = (cmd.data == {2'b00, exp_r});
              pos_nxt    = 8'd1;
            end else if (pos_r <= len) begin
              sum_nxt = sum_r + cmd.data;
              if (exp_r == FREQ_BLOCK && pos_r >= FREQ_FIRST && pos_r <= FREQ_LAST) begin
                freq_nxt = {freq_r[23:0], cmd.data};
              end
              pos_nxt = pos_r + 8'd1;
            end else if (!num_ok_r || cmd.data != sum_r) begin
              // Checksum position: a wrong number or sum ends the transfer.
              recv_nxt = 1'b0;
              res_push = 1'b1;
              res.ev   = EV_BAD;
            end else begin
              if (rep_inc >= row_count(row_r)) begin
                row_adv = row_r + ROW_IDX_W'(1);
                rep_nxt = 6'd0;
              end else begin
                rep_nxt = rep_inc;
              end
              row_nxt  = row_adv;
              last     = ({1'b0, row_adv} >= ROWS_END) || (row_adv == '0);
              res_push = 1'b1;
              res.ev   = last ? EV_DONE : EV_ACK;
              res.fv   = (exp_r == FREQ_BLOCK);
              res.freq = (exp_r == FREQ_BLOCK) ? freq_r : 32'd0;
              exp_nxt  = exp_r + 6'd1;
              if (last) begin
                recv_nxt = 1'b0;
              end
              pos_nxt    = 8'd0;
              num_ok_nxt = 1'b0;
              sum_nxt    = 8'd0;
              freq_nxt   = 32'd0;
              tick_nxt   = 16'd0;
            end
          end
          default: begin
            recv_nxt = recv_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
      recv_r    <= 1'b0;
      row_r     <= '0;
      rep_r     <= 6'd0;
      exp_r     <= 6'd0;
      pos_r     <= 8'd0;
      num_ok_r  <= 1'b0;
      sum_r     <= 8'd0;
      freq_r    <= 32'd0;
      tick_r    <= 16'd0;
    end else begin
      if (cfg_we) begin
        timeout_r <= cfg_timeout_ticks;
      end
      recv_r   <= recv_nxt;
      row_r    <= row_nxt;
      rep_r    <= rep_nxt;
      exp_r    <= exp_nxt;
      pos_r    <= pos_nxt;
      num_ok_r <= num_ok_nxt;
      sum_r    <= sum_nxt;
      freq_r   <= freq_nxt;
      tick_r   <= tick_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/clone_block_receiver_top.sv]
`default_nettype none

// Clone block receiver: after a start command it checks a memory clone transfer of
// fixed-length blocks (number byte, payload, 8-bit sum) and reports one event per
// finished block, a bad block or a timeout, with the frequency taken from block 8.
// Both sides are queues of two entries; the back end takes one item every clock
// cycle whenever the command queue holds one and the result queue has room. An item
// is registered in the command queue and its result in the result queue. The user
// must write the timeout register only while idle; the block does not enforce it.

module clone_block_receiver_top
  import cbr_pkg::*;
#(
  parameter int unsigned TABLE_ROWS = TABLE_ROWS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_timeout_ticks,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [1:0]       out_event_res,
  output logic [5:0]       out_block_number,
  output logic             out_freq_valid,
  output logic [31:0]      out_memory_freq
);

  cmd_t                    cmd;
  logic                    cmd_empty;
  logic                    cmd_pop;
  logic                    res_full;
  logic                    res_push;
  res_t                    res;
  logic [$bits(res_t)-1:0] res_bits;
  res_t                    res_out;

  cbr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_opcode    (in_opcode),
    .in_data_byte (in_data_byte),
    .in_full      (in_full),
    .cmd_pop      (cmd_pop),
    .cmd          (cmd),
    .cmd_empty    (cmd_empty)
  );

  cbr_back #(
    .TABLE_ROWS(TABLE_ROWS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_timeout_ticks (cfg_timeout_ticks),
    .cmd               (cmd),
    .cmd_empty         (cmd_empty),
    .cmd_pop           (cmd_pop),
    .res_full          (res_full),
    .res_push          (res_push),
    .res               (res)
  );

  cbr_fifo #(
    .WIDTH($bits(res_t))
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_bits),
    .empty (out_empty)
  );

  assign res_out          = res_t'(res_bits);
  assign out_event_res    = res_out.ev;
  assign out_block_number = res_out.blk;
  assign out_freq_valid   = res_out.fv;
  assign out_memory_freq  = res_out.freq;

endmodule

`default_nettype wire

[dv/tb_top.sv]
`default_nettype none

module tb_top;
  import cbr_pkg::*;

  localparam logic [5:0] LAST_BLK   = 6'd49;
  localparam int         NUM_BLKS   = 50;
  localparam int         SETTLE     = 8;
  localparam int         MAX_CYCLES = 2000000;

  typedef enum int {
    FLT_NONE,
    FLT_NUMBER,
    FLT_SUM,
    FLT_TIMEOUT,
    FLT_DROP
  } fault_t;

  logic        clk               = 1'b0;
  logic        rst_n             = 1'b0;
  logic        cfg_we            = 1'b0;
  logic [15:0] cfg_timeout_ticks = '0;
  logic        in_push           = 1'b0;
  logic        in_full;
  logic [1:0]  in_opcode         = '0;
  logic [7:0]  in_data_byte      = '0;
  logic        out_empty;
  logic        out_pop           = 1'b0;
  logic [1:0]  out_event_res;
  logic [5:0]  out_block_number;
  logic        out_freq_valid;
  logic [31:0] out_memory_freq;

  always #5 clk = ~clk;

  clone_block_receiver_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_timeout_ticks (cfg_timeout_ticks),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_opcode         (in_opcode),
    .in_data_byte      (in_data_byte),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_event_res     (out_event_res),
    .out_block_number  (out_block_number),
    .out_freq_valid    (out_freq_valid),
    .out_memory_freq   (out_memory_freq)
  );

  cmd_t pending_cmds[$];
  res_t expected_events[$];
  int   send_idle_pct = 0;
  int   pop_idle_pct  = 0;
  int   errors        = 0;
  int   cycles        = 0;
  int   queued_items  = 0;
  int   cur_timeout   = TIMEOUT_RESET;

  // Receiver state as the block should hold it.
  logic        rx_active  = 1'b0;
  logic [5:0]  rx_blk     = '0;
  logic [7:0]  rx_pos     = '0;
  logic        rx_num_ok  = 1'b0;
  logic [7:0]  rx_sum     = '0;
  logic [31:0] rx_freq    = '0;
  logic [15:0] rx_ticks   = '0;
  logic [15:0] rx_timeout = TIMEOUT_RESET;

  // Payload length by block number: the length table expanded over its repeats.
  function automatic logic [7:0] payload_len(input logic [5:0] blk);
    logic [7:0] len;
    case (blk)
      6'd0:         len = 8'd2;
      6'd1:         len = 8'd40;
      6'd2, 6'd4:   len = 8'd208;
      6'd3, 6'd5:   len = 8'd182;
      6'd6:         len = 8'd198;
      6'd7:         len = 8'd53;
      6'd48, 6'd49: len = 8'd118;
      default:      len = 8'd130;
    endcase
    return len;
  endfunction

  function automatic void clear_block();
    rx_pos    = '0;
    rx_num_ok = 1'b0;
    rx_sum    = '0;
    rx_freq   = '0;
    rx_ticks  = '0;
  endfunction

  function automatic bit predict_event(input op_t op, input logic [7:0] d, output res_t ev);
    logic [7:0] len;
    ev  = '0;
    len = payload_len(rx_blk);
    if (op == OP_START) begin
      if (!rx_active) begin
        rx_active = 1'b1;
        rx_blk    = '0;
        clear_block();
      end
      return 1'b0;
    end
    if (!rx_active) return 1'b0;
    if (op == OP_DISC) begin
      rx_active = 1'b0;
      return 1'b0;
    end
    if (op == OP_TICK) begin
      if (rx_ticks != 16'hFFFF) rx_ticks = rx_ticks + 16'd1;
      if (rx_ticks >= rx_timeout) begin
        rx_active = 1'b0;
        ev.ev     = EV_TIMEOUT;
        ev.blk    = rx_blk;
        return 1'b1;
      end
      return 1'b0;
    end
    if (rx_pos == 8'd0) begin
      rx_num_ok = (d == {2'b00, rx_blk});
      rx_pos    = 8'd1;
      return 1'b0;
    end
    if (rx_pos <= len) begin
      rx_sum = rx_sum + d;
      if (rx_blk == FREQ_BLOCK && rx_pos >= FREQ_FIRST && rx_pos <= FREQ_LAST) begin
        rx_freq = {rx_freq[23:0], d};
      end
      rx_pos = rx_pos + 8'd1;
      return 1'b0;
    end
    // Checksum byte closes the block.
    ev.blk = rx_blk;
    if (!rx_num_ok || d != rx_sum) begin
      rx_active = 1'b0;
      ev.ev     = EV_BAD;
      return 1'b1;
    end
    ev.ev = (rx_blk == LAST_BLK) ? EV_DONE : EV_ACK;
    if (rx_blk == FREQ_BLOCK) begin
      ev.fv   = 1'b1;
      ev.freq = rx_freq;
    end
    if (rx_blk == LAST_BLK) rx_active = 1'b0;
    rx_blk = rx_blk + 6'd1;
    clear_block();
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Driver: presents the next pending item and predicts each transfer.
  always @(posedge clk) begin : drive_proc
    res_t ev;
    cmd_t c;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        if (predict_event(op_t'(in_opcode), in_data_byte, ev)) expected_events.push_back(ev);
      end
      if (!in_push || !in_full) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          c = pending_cmds.pop_front();
          in_push      <= 1'b1;
          in_opcode    <= c.op;
          in_data_byte <= c.data;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each popped event with the oldest prediction.
  always @(posedge clk) begin : check_proc
    res_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_events.size() == 0) begin
          $display("%0t: event expected none actual ev=%0d blk=%0d fv=%0d freq=%0d", $time,
                   out_event_res, out_block_number, out_freq_valid, out_memory_freq);
          errors++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_res", 32'(want.ev), 32'(out_event_res));
          check_field("block_number", 32'(want.blk), 32'(out_block_number));
          check_field("freq_valid", 32'(want.fv), 32'(out_freq_valid));
          check_field("memory_freq", want.freq, out_memory_freq);
        end
      end
      out_pop <= ($urandom_range(99) >= pop_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == MAX_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  function automatic void add_cmd(input op_t op, input logic [7:0] d);
    cmd_t c;
    c.op   = op;
    c.data = d;
    pending_cmds.push_back(c);
    queued_items++;
  endfunction

  task automatic drain();
    @(negedge clk);
    while (pending_cmds.size() != 0 || in_push || expected_events.size() != 0) @(negedge clk);
  endtask

  task automatic set_phase(input logic [15:0] tmo, input int send_pct, input int pop_pct);
    drain();
    // Items that give no event may still be in the pipe.
    repeat (SETTLE) @(negedge clk);
    @(posedge clk);
    cfg_we            <= 1'b1;
    cfg_timeout_ticks <= tmo;
    @(posedge clk);
    cfg_we        <= 1'b0;
    rx_timeout    = tmo;
    cur_timeout   = tmo;
    send_idle_pct = send_pct;
    pop_idle_pct  = pop_pct;
  endtask

  // One clone transfer of nblk blocks; a fault, if any, hits the last block.
  task automatic gen_session(input int nblk, input fault_t flt);
    int         len;
    int         stop;
    int         ticks;
    bit         hit;
    logic [7:0] sum;
    logic [7:0] d;
    add_cmd(OP_START, rnd8());
    for (int b = 0; b < nblk; b++) begin
      len   = payload_len(6'(b));
      hit   = (b == nblk - 1) && (flt != FLT_NONE);
      stop  = len + 2;
      sum   = '0;
      ticks = 0;
      if (hit && (flt == FLT_TIMEOUT || flt == FLT_DROP)) stop = $urandom_range(0, len + 1);
      for (int p = 0; p < stop; p++) begin
        // Harmless noise: a tick short of the timeout, or a start that is ignored.
        if ($urandom_range(49) == 0) begin
          if (ticks + 1 < cur_timeout) begin
            add_cmd(OP_TICK, rnd8());
            ticks++;
          end else begin
            add_cmd(OP_START, rnd8());
          end
        end
        if (p == 0) begin
          d = 8'(b);
          if (hit && flt == FLT_NUMBER) d = d ^ 8'($urandom_range(1, 255));
        end else if (p <= len) begin
          d   = rnd8();
          sum = sum + d;
        end else begin
          d = sum;
          if (hit && flt == FLT_SUM) d = d ^ 8'($urandom_range(1, 255));
        end
        add_cmd(OP_BYTE, d);
      end
    end
    if (flt == FLT_TIMEOUT) begin
      repeat ((cur_timeout - ticks > 0) ? cur_timeout - ticks : 1) add_cmd(OP_TICK, rnd8());
    end else if (flt == FLT_DROP || nblk < NUM_BLKS) begin
      add_cmd(OP_DISC, rnd8());
    end
  endtask

  task automatic random_sessions(input int budget);
    int     target;
    int     nblk;
    bit     first;
    fault_t flt;
    target = queued_items + budget;
    first  = 1'b1;
    while (queued_items < target) begin
      nblk = ($urandom_range(5) == 0) ? 4 : $urandom_range(1, 3);
      flt  = FLT_NONE;
      if ($urandom_range(2) != 0) flt = fault_t'($urandom_range(1, 4));
      if (flt == FLT_TIMEOUT && cur_timeout > 64) flt = FLT_DROP;
      gen_session(nblk, flt);
      // Items on an idle link are ignored.
      repeat ($urandom_range(0, 2)) begin
        case ($urandom_range(2))
          0:       add_cmd(OP_BYTE, rnd8());
          1:       add_cmd(OP_TICK, rnd8());
          default: add_cmd(OP_DISC, rnd8());
        endcase
      end
      // Now and then hold the sender until every event is back.
      if (first || $urandom_range(7) == 0) drain();
      first = 1'b0;
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Idle link ignores everything but a start.
    add_cmd(OP_BYTE, 8'h00);
    add_cmd(OP_TICK, 8'hFF);
    add_cmd(OP_DISC, 8'hA5);
    // Good block 0 with extreme payload, a tick and an ignored start inside.
    add_cmd(OP_START, 8'h00);
    add_cmd(OP_BYTE, 8'h00);
    add_cmd(OP_BYTE, 8'hFF);
    add_cmd(OP_TICK, 8'h00);
    add_cmd(OP_BYTE, 8'hFF);
    add_cmd(OP_START, 8'hFF);
    add_cmd(OP_BYTE, 8'hFE);
    // Block 1 begins, then the link drops silently.
    add_cmd(OP_BYTE, 8'h01);
    add_cmd(OP_DISC, 8'h00);
    // Wrong block number: the block is read to its end before the abort.
    add_cmd(OP_START, 8'h00);
    add_cmd(OP_BYTE, 8'h80);
    add_cmd(OP_BYTE, 8'h01);
    add_cmd(OP_BYTE, 8'h02);
    add_cmd(OP_BYTE, 8'h03);
    // Wrong checksum.
    add_cmd(OP_START, 8'h00);
    add_cmd(OP_BYTE, 8'h00);
    add_cmd(OP_BYTE, 8'h10);
    add_cmd(OP_BYTE, 8'h20);
    add_cmd(OP_BYTE, 8'h31);

    // A zero timeout aborts on the first tick.
    set_phase(16'd0, 0, 0);
    add_cmd(OP_START, 8'h00);
    add_cmd(OP_TICK, 8'h00);
    set_phase(16'd3, 0, 0);
    add_cmd(OP_START, 8'h00);
    add_cmd(OP_BYTE, 8'h00);
    repeat (3) add_cmd(OP_TICK, rnd8());

    set_phase(16'd1, 23, 67);
    random_sessions(650);

    set_phase(16'($urandom_range(2, 40)), 67, 23);
    // Deep enough to report the frequency from block 8.
    gen_session(10, FLT_NONE);
    random_sessions(650);

    set_phase(16'hFFFF, 0, 0);
    gen_session(NUM_BLKS, FLT_NONE);
    random_sessions(650);

    drain();
    repeat (SETTLE) @(negedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
